// ----- design/assert_macros.svh -----
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ffha_pkg.sv -----
// shared types and codes of the first-fit heap allocator
// no dependencies
package ffha_pkg;

  // datapath operation codes issued by the controller
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_SRD   = 4'd2;
  localparam op_t OP_SCHK  = 4'd3;
  localparam op_t OP_NRD   = 4'd4;
  localparam op_t OP_NCHK  = 4'd5;
  localparam op_t OP_MERGE = 4'd6;
  localparam op_t OP_DRD   = 4'd7;
  localparam op_t OP_DWR   = 4'd8;
  localparam op_t OP_URD   = 4'd9;
  localparam op_t OP_UWR   = 4'd10;
  localparam op_t OP_SPLIT = 4'd11;
  localparam op_t OP_AWR   = 4'd12;
  localparam op_t OP_OUT   = 4'd13;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  // command from controller to datapath
  typedef struct packed {
    op_t op;
  } ffha_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_free;
    logic match;
    logic last;
    logic bad;
    logic split_ok;
    logic k_nz;
    logic drd_more;
    logic urd_more;
  } ffha_stat_t;

endpackage

// ----- design/ffha_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ffha_ctl.sv -----
// controller state machine of the heap allocator
// depends on ffha_pkg
module ffha_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_cmd_t  cmd
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_NRD   = 4'd3;
  localparam logic [3:0] S_NCHK  = 4'd4;
  localparam logic [3:0] S_MERGE = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DWR   = 4'd7;
  localparam logic [3:0] S_URD   = 4'd8;
  localparam logic [3:0] S_UWR   = 4'd9;
  localparam logic [3:0] S_SPLIT = 4'd10;
  localparam logic [3:0] S_AWR   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.op    = OP_SRD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd.op = OP_SCHK;
        if (stat.match && !stat.bad) begin
          if (!stat.is_free) begin
            state_nxt = stat.split_ok ? S_URD : S_AWR;
          end else begin
            state_nxt = stat.last ? S_MERGE : S_NRD;
          end
        end else if (stat.match || stat.last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_NRD: begin
        cmd.op    = OP_NRD;
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        cmd.op    = OP_NCHK;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.op    = OP_MERGE;
        state_nxt = stat.k_nz ? S_DRD : S_FIN;
      end
      S_DRD: begin
        cmd.op    = OP_DRD;
        state_nxt = stat.drd_more ? S_DWR : S_FIN;
      end
      S_DWR: begin
        cmd.op    = OP_DWR;
        state_nxt = S_DRD;
      end
      S_URD: begin
        cmd.op    = OP_URD;
        state_nxt = stat.urd_more ? S_UWR : S_SPLIT;
      end
      S_UWR: begin
        cmd.op    = OP_UWR;
        state_nxt = S_URD;
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.op    = OP_AWR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/ffha_dp.sv -----
// datapath of the heap allocator: block table ram, indexes, free sum, result
// depends on ffha_pkg and ffha_ram
module ffha_dp #(
  parameter int HEAP_BYTES      = 65536,
  parameter int MIN_BLOCK_BYTES = 16,
  parameter int HEADER_BYTES    = 16,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffha_pkg::ffha_cmd_t  cmd,
  output ffha_pkg::ffha_stat_t stat,
  input  logic                 in_cmd,
  input  logic [15:0]          in_req_size,
  input  logic [15:0]          in_free_addr,
  output logic [1:0]           out_status,
  output logic [15:0]          out_payload_offset,
  output logic [15:0]          out_free_bytes
);
  import ffha_pkg::*;

  localparam int HW   = $clog2(HEAP_BYTES) + 1;
  localparam int W    = (HW > 17) ? HW : 17;
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int DW   = 2 * W + 1;
  localparam logic [W-1:0]  HDR    = W'(HEADER_BYTES);
  localparam logic [W-1:0]  MINB   = W'(MIN_BLOCK_BYTES);
  localparam logic [W-1:0]  PAY0   = W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_BLOCKS);

  // table ram and entry 0 reset substitute
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, ram_q, q;
  logic          e0w_r, e0w_nxt, rd0_r, rd0_nxt;

  ffha_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign q = rd0_r ? {1'b0, PAY0, {W{1'b0}}} : ram_q;

  logic          q_used;
  logic [W-1:0]  q_pay, q_off;
  assign q_used = q[DW-1];
  assign q_pay  = q[2*W-1:W];
  assign q_off  = q[W-1:0];

  // working registers
  logic          cmd_r, cmd_nxt, split_r, split_nxt, nxtv_r, nxtv_nxt;
  logic [W-1:0]  size_r, size_nxt, addr_r, addr_nxt, ftot_r, ftot_nxt;
  logic [IW-1:0] idx_r, idx_nxt, hit_r, hit_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, nx_r, nx_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [W-1:0]  poff_r, poff_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [15:0]   opo_r, opo_nxt, ofb_r, ofb_nxt;

  logic [W-1:0]  cur_pay, cur_off, req_w;
  logic [CW-1:0] idx_p1, hit_p1;
  logic          pf, nf;
  logic [1:0]    k;
  logic [IW-1:0] p_idx;
  logic [W-1:0]  m_pay, m_off, hdr_k;

  assign cur_pay = cur_r[2*W-1:W];
  assign cur_off = cur_r[W-1:0];
  assign req_w   = W'(in_req_size);
  assign idx_p1  = CW'(idx_r) + CW'(1);
  assign hit_p1  = CW'(hit_r) + CW'(1);

  // merge decision with free neighbours
  assign pf    = (hit_r != '0) && !prev_r[DW-1];
  assign nf    = nxtv_r && !nx_r[DW-1];
  assign k     = {1'b0, pf} + {1'b0, nf};
  assign p_idx = pf ? hit_r - IW'(1) : hit_r;
  assign m_off = pf ? prev_r[W-1:0] : cur_off;
  assign m_pay = (pf ? prev_r[2*W-1:W] + HDR : '0) + cur_pay
               + (nf ? HDR + nx_r[2*W-1:W] : '0);
  assign hdr_k = (k == 2'd2) ? HDR + HDR : ((k == 2'd1) ? HDR : '0);

  // status toward the controller
  always_comb begin
    stat.is_free  = cmd_r;
    stat.match    = cmd_r ? ((q_off + HDR) == addr_r) : (!q_used && q_pay >= size_r);
    stat.last     = idx_p1 >= count_r;
    stat.bad      = cmd_r && !q_used;
    stat.split_ok = (q_pay >= size_r + MINB + HDR) && (count_r < MAXC);
    stat.k_nz     = pf || nf;
    stat.drd_more = CW'(idx_r) < count_r;
    stat.urd_more = CW'(idx_r) > hit_p1;
  end

  // ram ports
  always_comb begin
    re    = 1'b0;
    raddr = idx_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = q;
    unique case (cmd.op) inside
      OP_SRD: re = 1'b1;
      OP_NRD: begin
        re    = 1'b1;
        raddr = idx_r + IW'(1);
      end
      OP_DRD: begin
        re    = stat.drd_more;
        raddr = idx_r + IW'(k);
      end
      OP_URD: begin
        re    = stat.urd_more;
        raddr = idx_r - IW'(1);
      end
      OP_DWR, OP_UWR: we = 1'b1;
      OP_MERGE: begin
        we    = 1'b1;
        waddr = p_idx;
        wdata = {1'b0, m_pay, m_off};
      end
      OP_SPLIT: begin
        we    = 1'b1;
        waddr = hit_r + IW'(1);
        wdata = {1'b0, cur_pay - size_r - HDR, cur_off + HDR + size_r};
      end
      OP_AWR: begin
        we    = 1'b1;
        waddr = hit_r;
        wdata = {1'b1, (split_r ? size_r : cur_pay), cur_off};
      end
      default: ;
    endcase
  end

  // register updates
  always_comb begin
    cmd_nxt   = cmd_r;
    split_nxt = split_r;
    nxtv_nxt  = nxtv_r;
    size_nxt  = size_r;
    addr_nxt  = addr_r;
    ftot_nxt  = ftot_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    nx_nxt    = nx_r;
    st_nxt    = st_r;
    poff_nxt  = poff_r;
    ost_nxt   = ost_r;
    opo_nxt   = opo_r;
    ofb_nxt   = ofb_r;
    e0w_nxt   = e0w_r || (we && waddr == '0);
    rd0_nxt   = re ? (raddr == '0 && !e0w_r) : rd0_r;
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_nxt   = in_cmd;
        size_nxt  = (req_w < MINB) ? MINB : req_w;
        addr_nxt  = W'(in_free_addr);
        idx_nxt   = '0;
        nxtv_nxt  = 1'b0;
        split_nxt = 1'b0;
        st_nxt    = ST_OK;
        poff_nxt  = '0;
      end
      OP_SCHK: begin
        if (stat.match) begin
          hit_nxt = idx_r;
          cur_nxt = q;
          if (!cmd_r && stat.split_ok) begin
            split_nxt = 1'b1;
            idx_nxt   = IW'(count_r);
          end
          if (stat.bad) begin
            st_nxt = ST_BADADDR;
          end
        end else begin
          prev_nxt = q;
          idx_nxt  = idx_r + IW'(1);
          if (stat.last) begin
            st_nxt = cmd_r ? ST_BADADDR : ST_NOFIT;
          end
        end
      end
      OP_NCHK: begin
        nx_nxt   = q;
        nxtv_nxt = 1'b1;
      end
      OP_MERGE: begin
        count_nxt = count_r - CW'(k);
        ftot_nxt  = ftot_r + cur_pay + hdr_k;
        idx_nxt   = p_idx + IW'(1);
      end
      OP_DWR: idx_nxt = idx_r + IW'(1);
      OP_UWR: idx_nxt = idx_r - IW'(1);
      OP_SPLIT: begin
        count_nxt = count_r + CW'(1);
        ftot_nxt  = ftot_r - size_r - HDR;
      end
      OP_AWR: begin
        if (!split_r) begin
          ftot_nxt = ftot_r - cur_pay;
        end
        poff_nxt = cur_off + HDR;
      end
      OP_OUT: begin
        ost_nxt = st_r;
        opo_nxt = poff_r[15:0];
        ofb_nxt = ftot_r[15:0];
      end
      default: ;
    endcase
  end

  // control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
      ftot_r  <= PAY0;
      e0w_r   <= 1'b0;
      rd0_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ftot_r  <= ftot_nxt;
      e0w_r   <= e0w_nxt;
      rd0_r   <= rd0_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    split_r <= split_nxt;
    nxtv_r  <= nxtv_nxt;
    size_r  <= size_nxt;
    addr_r  <= addr_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    nx_r    <= nx_nxt;
    st_r    <= st_nxt;
    poff_r  <= poff_nxt;
    ost_r   <= ost_nxt;
    opo_r   <= opo_nxt;
    ofb_r   <= ofb_nxt;
  end

  assign out_status         = ost_r;
  assign out_payload_offset = opo_r;
  assign out_free_bytes     = ofb_r;

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// First-fit heap allocator with coalescing. The heap is kept as an address-ordered
// table of blocks in a single-port-write ram of MAX_BLOCKS entries. A request walks
// the table one entry at a time (read, then check); an allocate that splits then
// shifts the entries above it up, and a free that merges shifts them down, each
// moved entry read and then written. One request is in work at a time, and the
// next is taken while the previous result still waits on the output. There is no
// clearing pass after reset: entry 0 reads as the whole heap until written.
// Depends on ffha_pkg, ffha_ctl, ffha_dp.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES      = 65536,
  parameter int MIN_BLOCK_BYTES = 16,
  parameter int HEADER_BYTES    = 16,
  parameter int MAX_BLOCKS      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_free_bytes
);
  import ffha_pkg::*;

  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  // sequencer
  ffha_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // block table and arithmetic
  ffha_dp #(
    .HEAP_BYTES      (HEAP_BYTES),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_cmd             (in_cmd),
    .in_req_size        (in_req_size),
    .in_free_addr       (in_free_addr),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_free_bytes     (out_free_bytes)
  );

endmodule

// ----- design/ffha_checker.sv -----
// port-level checks of the heap allocator, bound to the top level
// depends on assert_macros.svh and ffha_pkg
`include "assert_macros.svh"

module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_payload_offset
);
  import ffha_pkg::*;

  // status is one of the three defined codes
  `ASSERT_ALWAYS(a_status_code, clk, rst_n, !out_valid || out_status == ST_OK || out_status == ST_NOFIT || out_status == ST_BADADDR, "bad status code")

  // a failed request carries no offset
  `ASSERT_ALWAYS(a_fail_zero, clk, rst_n, !out_valid || out_status == ST_OK || out_payload_offset == 16'd0, "offset on failed word")

  // one request in work at a time
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "accepted while busy")

  // a stalled result word stays
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "output word dropped")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_payload_offset (out_payload_offset)
);

// ----- sim/first_fit_heap_allocator_tb.sv -----
// self-checking testbench for the first-fit heap allocator
// depends on ffha_pkg and first_fit_heap_allocator; a scoreboard class predicts every result
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned HEAP_SZ  = 65536;
  localparam int unsigned MIN_BLK  = 16;
  localparam int unsigned HDR_SZ   = 16;
  localparam int unsigned TBL_SIZE = 64;
  localparam int          N_RANDOM = 1680;
  localparam logic        CMD_ALLOC = 1'b0;
  localparam logic        CMD_FREE  = 1'b1;

  // heap bookkeeping and expected results
  class heap_scoreboard;
    typedef struct {
      logic [1:0]  status;
      logic [15:0] offset;
      logic [15:0] free_bytes;
    } heap_result_t;

    int unsigned  blk_off[TBL_SIZE];
    int unsigned  blk_pay[TBL_SIZE];
    bit           blk_used[TBL_SIZE];
    int unsigned  blk_cnt;
    int unsigned  free_sum;
    heap_result_t pending[$];
    int errors, n_alloc, n_free, n_nofit, n_bad, n_full, n_checked;

    function new();
      for (int k = 0; k < TBL_SIZE; k++) begin
        blk_off[k] = 0;
        blk_pay[k] = 0;
        blk_used[k] = 0;
      end
      blk_pay[0] = HEAP_SZ - HDR_SZ;
      blk_cnt = 1;
      free_sum = HEAP_SZ - HDR_SZ;
    endfunction

    // remove table entry k, shifting the upper entries down
    function void remove_entry(int unsigned k);
      for (int unsigned j = k; j + 1 < blk_cnt; j++) begin
        blk_off[j] = blk_off[j+1];
        blk_pay[j] = blk_pay[j+1];
        blk_used[j] = blk_used[j+1];
      end
      blk_cnt--;
    endfunction

    function heap_result_t predict(logic cmd, logic [15:0] req, logic [15:0] addr);
      heap_result_t r;
      int unsigned sz;
      int i;
      r.offset = '0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
        n_alloc++;
        sz = (req < MIN_BLK) ? MIN_BLK : req;
        i = -1;
        for (int k = 0; k < blk_cnt; k++)
          if (i < 0 && !blk_used[k] && blk_pay[k] >= sz) i = k;
        if (i < 0) begin
          r.status = ST_NOFIT;
          n_nofit++;
        end else begin
          if (blk_pay[i] >= sz + MIN_BLK + HDR_SZ && blk_cnt < TBL_SIZE) begin
            for (int j = blk_cnt; j > i + 1; j--) begin
              blk_off[j] = blk_off[j-1];
              blk_pay[j] = blk_pay[j-1];
              blk_used[j] = blk_used[j-1];
            end
            blk_off[i+1] = blk_off[i] + HDR_SZ + sz;
            blk_pay[i+1] = blk_pay[i] - sz - HDR_SZ;
            blk_used[i+1] = 0;
            blk_pay[i] = sz;
            blk_cnt++;
            free_sum -= sz + HDR_SZ;
          end else begin
            // whole block goes out, note when only the full table prevented a split
            if (blk_pay[i] >= sz + MIN_BLK + HDR_SZ) n_full++;
            free_sum -= blk_pay[i];
          end
          blk_used[i] = 1;
          r.offset = 16'(blk_off[i] + HDR_SZ);
        end
      end else begin
        n_free++;
        i = -1;
        for (int k = 0; k < blk_cnt; k++)
          if (i < 0 && blk_off[k] + HDR_SZ == addr) i = k;
        if (i < 0 || !blk_used[i]) begin
          r.status = ST_BADADDR;
          n_bad++;
        end else begin
          blk_used[i] = 0;
          free_sum += blk_pay[i];
          // merge with the free block above, then with the one below
          if (i + 1 < blk_cnt && !blk_used[i+1]) begin
            blk_pay[i] += HDR_SZ + blk_pay[i+1];
            free_sum += HDR_SZ;
            remove_entry(i + 1);
          end
          if (i > 0 && !blk_used[i-1]) begin
            blk_pay[i-1] += HDR_SZ + blk_pay[i];
            free_sum += HDR_SZ;
            remove_entry(i);
          end
        end
      end
      r.free_bytes = 16'(free_sum);
      return r;
    endfunction

    function void note_word(logic cmd, logic [15:0] req, logic [15:0] addr);
      pending.push_back(predict(cmd, req, addr));
    endfunction

    function void check_word(logic [1:0] st, logic [15:0] off, logic [15:0] fb);
      heap_result_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d offset %0d free %0d",
                 $time, st, off, fb);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (off !== e.offset) begin
        $display("%0t: payload_offset mismatch: expected %0d actual %0d", $time, e.offset, off);
        errors++;
      end
      if (fb !== e.free_bytes) begin
        $display("%0t: free_bytes mismatch: expected %0d actual %0d", $time, e.free_bytes, fb);
        errors++;
      end
    endfunction

    // payload address of a random block in use, or -1 if none
    function int pick_used_addr();
      int idx[$];
      for (int k = 0; k < blk_cnt; k++)
        if (blk_used[k]) idx.push_back(k);
      if (idx.size() == 0) return -1;
      return int'(blk_off[idx[$urandom_range(idx.size() - 1)]] + HDR_SZ);
    endfunction

    // payload address of a random free block, or -1 if none
    function int pick_free_addr();
      int idx[$];
      for (int k = 0; k < blk_cnt; k++)
        if (!blk_used[k]) idx.push_back(k);
      if (idx.size() == 0) return -1;
      return int'(blk_off[idx[$urandom_range(idx.size() - 1)]] + HDR_SZ);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = 1'b0;
  logic [15:0] in_req_size = '0;
  logic [15:0] in_free_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_payload_offset;
  logic [15:0] out_free_bytes;

  heap_scoreboard heap_sb = new();
  int  words_in = 0;
  int  stall_left = 0;
  bit  stall_done = 1'b0;
  bit  max_blocks_seen = 1'b0;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_req_size(in_req_size), .in_free_addr(in_free_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_payload_offset(out_payload_offset),
    .out_free_bytes(out_free_bytes)
  );

  always #10 clk = ~clk;

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        heap_sb.note_word(in_cmd, in_req_size, in_free_addr);
        words_in++;
        if (heap_sb.blk_cnt == TBL_SIZE) max_blocks_seen = 1'b1;
      end
      if (out_valid && out_ready)
        heap_sb.check_word(out_status, out_payload_offset, out_free_bytes);
    end
  end

  // no idling in this window of words
  function automatic bit quiet_window();
    return words_in >= 600 && words_in < 850;
  endfunction

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!stall_done && words_in >= 950) begin
      stall_done <= 1'b1;
      stall_left <= 600;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || ($urandom_range(99) >= 24);
    end
  end

  // offer one word and hold it until taken
  task automatic send_word(logic cmd, logic [15:0] req, logic [15:0] addr);
    int target;
    target = words_in + 1;
    while (!quiet_window() && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_req_size = req;
    in_free_addr = addr;
    do @(negedge clk); while (words_in != target);
  endtask

  // build one random word, mostly well-formed requests
  task automatic send_random(int n);
    bit          alloc_heavy;
    int          pick, a;
    logic        cmd;
    logic [15:0] req, addr;
    alloc_heavy = ((n / 200) % 2) == 0;
    pick = $urandom_range(99);
    req = 16'($urandom);
    addr = 16'($urandom);
    if (pick < (alloc_heavy ? 75 : 35)) begin
      cmd = CMD_ALLOC;
      case ($urandom_range(9))
        0: req = 16'($urandom);
        1: req = 16'($urandom_range(4096));
        2: req = 16'($urandom_range(15));
        default: req = 16'($urandom_range(200));
      endcase
    end else begin
      cmd = CMD_FREE;
      case ($urandom_range(9))
        0: addr = 16'($urandom);
        1: begin
          a = heap_sb.pick_free_addr();
          if (a >= 0) addr = 16'(a);
        end
        default: begin
          a = heap_sb.pick_used_addr();
          if (a >= 0) addr = 16'(a);
        end
      endcase
    end
    send_word(cmd, req, addr);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // directed: tiny and exact sizes, bad and double frees, merges, whole heap
    send_word(CMD_ALLOC, 16'd0, 16'hFFFF);
    send_word(CMD_ALLOC, 16'd15, 16'd0);
    send_word(CMD_ALLOC, 16'd16, 16'd0);
    send_word(CMD_ALLOC, 16'd17, 16'd0);
    send_word(CMD_FREE, 16'hFFFF, 16'd16);
    send_word(CMD_FREE, 16'd0, 16'd16);
    send_word(CMD_FREE, 16'd0, 16'd0);
    send_word(CMD_FREE, 16'd0, 16'hFFFF);
    send_word(CMD_FREE, 16'd0, 16'd1);
    send_word(CMD_ALLOC, 16'hFFFF, 16'd0);
    send_word(CMD_FREE, 16'd0, 16'd48);
    send_word(CMD_FREE, 16'd0, 16'd112);
    send_word(CMD_FREE, 16'd0, 16'd80);
    send_word(CMD_ALLOC, 16'(HEAP_SZ - HDR_SZ), 16'd0);
    send_word(CMD_ALLOC, 16'd0, 16'd0);
    send_word(CMD_FREE, 16'd0, 16'd16);
    send_word(CMD_ALLOC, 16'(HEAP_SZ - HDR_SZ - 32), 16'd0);
    send_word(CMD_FREE, 16'd0, 16'd16);
    send_word(CMD_ALLOC, 16'(HEAP_SZ - HDR_SZ - 31), 16'd0);
    send_word(CMD_FREE, 16'd0, 16'd16);
    // fill the table with minimum blocks so splits are refused
    for (int n = 0; n < 70; n++) send_word(CMD_ALLOC, 16'd0, 16'($urandom));
    for (int n = 0; n < N_RANDOM; n++) send_random(n);
    @(negedge clk);
    in_valid = 1'b0;
    while (heap_sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("covered %0d allocates (%0d without fit, %0d unsplit on a full table)",
             heap_sb.n_alloc, heap_sb.n_nofit, heap_sb.n_full);
    $display("and %0d frees (%0d rejected), %0d result words checked, table full seen: %0d",
             heap_sb.n_free, heap_sb.n_bad, heap_sb.n_checked, max_blocks_seen);
    if (heap_sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_ctl.sv
design/ffha_dp.sv
design/first_fit_heap_allocator.sv
design/ffha_checker.sv
sim/first_fit_heap_allocator_tb.sv
